### design/ps2mct_pkg.sv
package ps2mct_pkg;

   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;

   localparam logic [7:0] ACK_BYTE      = 8'hFA;
   localparam logic [7:0] SELFTEST_PASS = 8'hAA;
   localparam logic [7:0] ENABLE_CMD    = 8'hF4;
   localparam int         X_SIGN_POS    = 4;   // status bit 0x10
   localparam int         Y_SIGN_POS    = 5;   // status bit 0x20

   localparam int RX_BYTE_W  = 8;
   localparam int DELTA_W    = RX_BYTE_W + 1;
   localparam int CURSOR_X_W = 10;
   localparam int CURSOR_Y_W = 9;

   localparam int POS_X_W = (SCREEN_WIDTH  > 1) ? $clog2(SCREEN_WIDTH)  : 1;
   localparam int POS_Y_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
   localparam int SUM_X_W = ((POS_X_W > DELTA_W) ? POS_X_W : DELTA_W) + 2;
   localparam int SUM_Y_W = ((POS_Y_W > DELTA_W) ? POS_Y_W : DELTA_W) + 2;

   localparam logic [POS_X_W-1:0] POS_X_RESET = POS_X_W'(SCREEN_WIDTH / 2);
   localparam logic [POS_Y_W-1:0] POS_Y_RESET = POS_Y_W'(SCREEN_HEIGHT / 2);
   localparam logic signed [SUM_X_W-1:0] SUM_X_MAX = SUM_X_W'(SCREEN_WIDTH - 1);
   localparam logic signed [SUM_Y_W-1:0] SUM_Y_MAX = SUM_Y_W'(SCREEN_HEIGHT - 1);

   typedef enum logic [1:0] {
      COUNT_FIRST  = 2'd0,
      COUNT_SECOND = 2'd1,
      COUNT_THIRD  = 2'd2
   } byte_count_type;

   typedef struct packed {
      logic                 valid;
      logic [RX_BYTE_W-1:0] rx_byte;
   } byte_beat_type;

endpackage

### design/ps2mct_in_stage.sv
module ps2mct_in_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ps2mct_pkg::RX_BYTE_W-1:0] req_rx_byte,
   input  logic                            advance,
   output ps2mct_pkg::byte_beat_type       beat
);

   logic                             valid_ff, valid_in;
   logic [ps2mct_pkg::RX_BYTE_W-1:0] byte_ff, byte_in;

   // hold the byte while the tracker cannot consume it
   assign req_stall = valid_ff && !advance;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         if (req_valid) begin
            byte_in = req_rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign beat.valid   = valid_ff;
   assign beat.rx_byte = byte_ff;

endmodule

### design/ps2mct_tracker.sv
module ps2mct_tracker (
   input  logic                             clock,
   input  logic                             reset,
   input  ps2mct_pkg::byte_beat_type        beat,
   output logic                             advance,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ps2mct_pkg::CURSOR_X_W-1:0] rsp_cursor_x,
   output logic [ps2mct_pkg::CURSOR_Y_W-1:0] rsp_cursor_y,
   output logic [ps2mct_pkg::RX_BYTE_W-1:0]  rsp_status_byte,
   output logic [ps2mct_pkg::RX_BYTE_W-1:0]  rsp_x_byte,
   output logic [ps2mct_pkg::RX_BYTE_W-1:0]  rsp_y_byte,
   output logic                             rsp_send_enable_request
);

   ps2mct_pkg::byte_count_type count_ff, count_in;
   logic [ps2mct_pkg::RX_BYTE_W-1:0] first_ff, first_in;
   logic [ps2mct_pkg::RX_BYTE_W-1:0] second_ff, second_in;
   logic [ps2mct_pkg::POS_X_W-1:0]   pos_x_ff, pos_x_in;
   logic [ps2mct_pkg::POS_Y_W-1:0]   pos_y_ff, pos_y_in;

   logic                              out_valid_ff, out_valid_in;
   logic [ps2mct_pkg::CURSOR_X_W-1:0] out_x_ff;
   logic [ps2mct_pkg::CURSOR_Y_W-1:0] out_y_ff;
   logic [ps2mct_pkg::RX_BYTE_W-1:0]  out_status_ff, out_xb_ff, out_yb_ff;
   logic                              out_enable_ff;

   logic out_ready, packet_end, finish, enable_req;
   logic signed [ps2mct_pkg::DELTA_W-1:0] delta_x, delta_y;
   logic signed [ps2mct_pkg::SUM_X_W-1:0] sum_x;
   logic signed [ps2mct_pkg::SUM_Y_W-1:0] sum_y;
   logic [ps2mct_pkg::POS_X_W-1:0] clamp_x;
   logic [ps2mct_pkg::POS_Y_W-1:0] clamp_y;

   assign out_ready = !out_valid_ff || !rsp_stall;

   always_comb begin
      unique case (count_ff)
         ps2mct_pkg::COUNT_FIRST:  packet_end = 1'b0;
         ps2mct_pkg::COUNT_SECOND: packet_end = 1'b0;
         default:                  packet_end = 1'b1;
      endcase
   end

   assign advance = beat.valid && (!packet_end || out_ready);
   assign finish  = advance && packet_end;

   assign enable_req = (first_ff == ps2mct_pkg::ACK_BYTE)
                    && (second_ff == ps2mct_pkg::SELFTEST_PASS);

   // 9-bit deltas: sign bit from the status byte above the data byte
   assign delta_x = {first_ff[ps2mct_pkg::X_SIGN_POS], second_ff};
   assign delta_y = {first_ff[ps2mct_pkg::Y_SIGN_POS], beat.rx_byte};

   assign sum_x = ps2mct_pkg::SUM_X_W'(signed'({1'b0, pos_x_ff}))
                + ps2mct_pkg::SUM_X_W'(delta_x);
   assign sum_y = ps2mct_pkg::SUM_Y_W'(signed'({1'b0, pos_y_ff}))
                + ps2mct_pkg::SUM_Y_W'(delta_y);

   always_comb begin
      priority if (sum_x < 0) begin
         clamp_x = '0;
      end else if (sum_x > ps2mct_pkg::SUM_X_MAX) begin
         clamp_x = ps2mct_pkg::POS_X_W'(ps2mct_pkg::SCREEN_WIDTH - 1);
      end else begin
         clamp_x = sum_x[ps2mct_pkg::POS_X_W-1:0];
      end
      priority if (sum_y < 0) begin
         clamp_y = '0;
      end else if (sum_y > ps2mct_pkg::SUM_Y_MAX) begin
         clamp_y = ps2mct_pkg::POS_Y_W'(ps2mct_pkg::SCREEN_HEIGHT - 1);
      end else begin
         clamp_y = sum_y[ps2mct_pkg::POS_Y_W-1:0];
      end
   end

   always_comb begin
      count_in  = count_ff;
      first_in  = first_ff;
      second_in = second_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      if (advance) begin
         unique case (count_ff)
            ps2mct_pkg::COUNT_FIRST: begin
               first_in = beat.rx_byte;
               count_in = ps2mct_pkg::COUNT_SECOND;
            end
            ps2mct_pkg::COUNT_SECOND: begin
               second_in = beat.rx_byte;
               count_in  = ps2mct_pkg::COUNT_THIRD;
            end
            default: begin
               count_in = ps2mct_pkg::COUNT_FIRST;
               // a reset reply leaves the cursor where it is
               if (!enable_req) begin
                  pos_x_in = clamp_x;
                  pos_y_in = clamp_y;
               end
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_ready) begin
         out_valid_in = finish;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= ps2mct_pkg::COUNT_FIRST;
         first_ff     <= '0;
         second_ff    <= '0;
         pos_x_ff     <= ps2mct_pkg::POS_X_RESET;
         pos_y_ff     <= ps2mct_pkg::POS_Y_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         out_valid_ff <= out_valid_in;
      end
      if (finish) begin
         out_x_ff      <= ps2mct_pkg::CURSOR_X_W'(pos_x_in);
         out_y_ff      <= ps2mct_pkg::CURSOR_Y_W'(pos_y_in);
         out_status_ff <= first_ff;
         out_xb_ff     <= second_ff;
         out_yb_ff     <= beat.rx_byte;
         out_enable_ff <= enable_req;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_cursor_x            = out_x_ff;
   assign rsp_cursor_y            = out_y_ff;
   assign rsp_status_byte         = out_status_ff;
   assign rsp_x_byte              = out_xb_ff;
   assign rsp_y_byte              = out_yb_ff;
   assign rsp_send_enable_request = out_enable_ff;

endmodule

### design/ps2_mouse_cursor_tracker_top.sv
// PS/2 mouse packet decoder with a saturating cursor. Each beat on req_ carries one byte
// from the mouse port; every third byte closes a packet (status, X delta, Y delta) and
// yields one rsp_ beat, the first two bytes yield none. There is no resync: the block
// simply counts bytes from reset. The 9-bit X and Y deltas (sign bits 4 and 5 of the
// status byte) move a cursor that starts at the screen center and clamps to the screen;
// Y grows downward with a positive delta. A packet starting 0xFA, 0xAA is a reset reply:
// the cursor holds and rsp_send_enable_request tells the host to send 0xF4. One byte is
// accepted every clock cycle unless req_stall holds a closing byte while a result waits under
// rsp_stall; a closing byte passes one input register, the add-and-clamp and one result register.
module ps2_mouse_cursor_tracker_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ps2mct_pkg::RX_BYTE_W-1:0]  req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ps2mct_pkg::CURSOR_X_W-1:0] rsp_cursor_x,
   output logic [ps2mct_pkg::CURSOR_Y_W-1:0] rsp_cursor_y,
   output logic [ps2mct_pkg::RX_BYTE_W-1:0]  rsp_status_byte,
   output logic [ps2mct_pkg::RX_BYTE_W-1:0]  rsp_x_byte,
   output logic [ps2mct_pkg::RX_BYTE_W-1:0]  rsp_y_byte,
   output logic                             rsp_send_enable_request
);

   ps2mct_pkg::byte_beat_type beat;
   logic                      advance;

   ps2mct_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .beat        (beat)
   );

   ps2mct_tracker u_tracker (
      .clock                   (clock),
      .reset                   (reset),
      .beat                    (beat),
      .advance                 (advance),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_cursor_x            (rsp_cursor_x),
      .rsp_cursor_y            (rsp_cursor_y),
      .rsp_status_byte         (rsp_status_byte),
      .rsp_x_byte              (rsp_x_byte),
      .rsp_y_byte              (rsp_y_byte),
      .rsp_send_enable_request (rsp_send_enable_request)
   );

endmodule

### design/ps2mct_checker.sv
module ps2mct_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [ps2mct_pkg::CURSOR_X_W-1:0] rsp_cursor_x,
   input logic [ps2mct_pkg::CURSOR_Y_W-1:0] rsp_cursor_y,
   input logic [ps2mct_pkg::RX_BYTE_W-1:0]  rsp_status_byte,
   input logic [ps2mct_pkg::RX_BYTE_W-1:0]  rsp_x_byte,
   input logic                             rsp_send_enable_request
);

   // a stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cursor_x)
                                 && $stable(rsp_cursor_y))
      else $error("stalled result beat changed");

   a_x_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_cursor_x) < 32'(ps2mct_pkg::SCREEN_WIDTH))
      else $error("cursor_x outside screen");

   a_y_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_cursor_y) < 32'(ps2mct_pkg::SCREEN_HEIGHT))
      else $error("cursor_y outside screen");

   a_enable_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_send_enable_request
                    == ((rsp_status_byte == ps2mct_pkg::ACK_BYTE)
                        && (rsp_x_byte == ps2mct_pkg::SELFTEST_PASS)))
      else $error("enable request does not match reset reply bytes");

endmodule

bind ps2_mouse_cursor_tracker_top ps2mct_checker u_ps2mct_checker (
   .clock                   (clock),
   .reset                   (reset),
   .rsp_valid               (rsp_valid),
   .rsp_stall               (rsp_stall),
   .rsp_cursor_x            (rsp_cursor_x),
   .rsp_cursor_y            (rsp_cursor_y),
   .rsp_status_byte         (rsp_status_byte),
   .rsp_x_byte              (rsp_x_byte),
   .rsp_send_enable_request (rsp_send_enable_request)
);

### test/testbench.sv
typedef struct packed {
   logic [ps2mct_pkg::CURSOR_X_W-1:0] cursor_x;
   logic [ps2mct_pkg::CURSOR_Y_W-1:0] cursor_y;
   logic [ps2mct_pkg::RX_BYTE_W-1:0]  status_byte;
   logic [ps2mct_pkg::RX_BYTE_W-1:0]  x_byte;
   logic [ps2mct_pkg::RX_BYTE_W-1:0]  y_byte;
   logic                              enable_request;
} cursor_report_type;

class cursor_scoreboard_type;
   ps2mct_pkg::byte_count_type       bytes_held;
   logic [ps2mct_pkg::RX_BYTE_W-1:0] status_held;
   logic [ps2mct_pkg::RX_BYTE_W-1:0] x_held;
   int                               column;
   int                               row;
   cursor_report_type                pending[$];
   int                               errors;

   function new();
      bytes_held  = ps2mct_pkg::COUNT_FIRST;
      status_held = '0;
      x_held      = '0;
      column      = ps2mct_pkg::SCREEN_WIDTH / 2;
      row         = ps2mct_pkg::SCREEN_HEIGHT / 2;
      errors      = 0;
   endfunction

   static function int clamp_to_screen(int v, int limit);
      if (v < 0)
         return 0;
      if (v > limit - 1)
         return limit - 1;
      return v;
   endfunction

   // Advance the packet framing and queue a cursor report on every third byte.
   function void note_byte(logic [ps2mct_pkg::RX_BYTE_W-1:0] b);
      logic signed [ps2mct_pkg::DELTA_W-1:0] dx;
      logic signed [ps2mct_pkg::DELTA_W-1:0] dy;
      cursor_report_type                     r;
      unique case (bytes_held)
         ps2mct_pkg::COUNT_FIRST: begin
            status_held = b;
            bytes_held  = ps2mct_pkg::COUNT_SECOND;
         end
         ps2mct_pkg::COUNT_SECOND: begin
            x_held     = b;
            bytes_held = ps2mct_pkg::COUNT_THIRD;
         end
         default: begin
            bytes_held       = ps2mct_pkg::COUNT_FIRST;
            r.enable_request = (status_held == ps2mct_pkg::ACK_BYTE)
                            && (x_held == ps2mct_pkg::SELFTEST_PASS);
            if (!r.enable_request) begin
               // sign bit from the status byte sits above the data byte
               dx     = {status_held[ps2mct_pkg::X_SIGN_POS], x_held};
               dy     = {status_held[ps2mct_pkg::Y_SIGN_POS], b};
               column = clamp_to_screen(column + int'(dx), ps2mct_pkg::SCREEN_WIDTH);
               row    = clamp_to_screen(row + int'(dy), ps2mct_pkg::SCREEN_HEIGHT);
            end
            r.cursor_x    = ps2mct_pkg::CURSOR_X_W'(column);
            r.cursor_y    = ps2mct_pkg::CURSOR_Y_W'(row);
            r.status_byte = status_held;
            r.x_byte      = x_held;
            r.y_byte      = b;
            pending.push_back(r);
         end
      endcase
   endfunction

   function void compare_field(string name, int want, int got, realtime now);
      if (want != got) begin
         $display("%0.1f ns: %s mismatch, expected %0d, actual %0d", now, name, want, got);
         errors++;
      end
   endfunction

   function void check_report(cursor_report_type got, realtime now);
      cursor_report_type want;
      if (pending.size() == 0) begin
         $display("%0.1f ns: unexpected result beat, expected none, actual x=%0d y=%0d",
                  now, got.cursor_x, got.cursor_y);
         errors++;
         return;
      end
      want = pending.pop_front();
      compare_field("cursor_x", int'(want.cursor_x), int'(got.cursor_x), now);
      compare_field("cursor_y", int'(want.cursor_y), int'(got.cursor_y), now);
      compare_field("status_byte", int'(want.status_byte), int'(got.status_byte), now);
      compare_field("x_byte", int'(want.x_byte), int'(got.x_byte), now);
      compare_field("y_byte", int'(want.y_byte), int'(got.y_byte), now);
      compare_field("send_enable_request", int'(want.enable_request),
                    int'(got.enable_request), now);
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT     = 2000;
   localparam int ITEMS_PER_PHASE = 550;
   localparam int LONG_HOLD       = 300;

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_valid   = 1'b0;
   logic                              req_stall;
   logic [ps2mct_pkg::RX_BYTE_W-1:0]  req_rx_byte = '0;
   logic                              rsp_valid;
   logic                              rsp_stall   = 1'b0;
   logic [ps2mct_pkg::CURSOR_X_W-1:0] rsp_cursor_x;
   logic [ps2mct_pkg::CURSOR_Y_W-1:0] rsp_cursor_y;
   logic [ps2mct_pkg::RX_BYTE_W-1:0]  rsp_status_byte;
   logic [ps2mct_pkg::RX_BYTE_W-1:0]  rsp_x_byte;
   logic [ps2mct_pkg::RX_BYTE_W-1:0]  rsp_y_byte;
   logic                              rsp_send_enable_request;

   cursor_scoreboard_type cursor_sb = new();

   int send_idle_pct  = 31;
   int recv_idle_pct  = 60;
   int long_hold_left = 0;
   int bytes_sent     = 0;
   int quiet_cycles   = 0;

   ps2_mouse_cursor_tracker_top uut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_rx_byte             (req_rx_byte),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_cursor_x            (rsp_cursor_x),
      .rsp_cursor_y            (rsp_cursor_y),
      .rsp_status_byte         (rsp_status_byte),
      .rsp_x_byte              (rsp_x_byte),
      .rsp_y_byte              (rsp_y_byte),
      .rsp_send_enable_request (rsp_send_enable_request)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: check the beat taken at this edge, then pick the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         cursor_sb.check_report(cursor_report_type'({rsp_cursor_x, rsp_cursor_y,
                                                     rsp_status_byte, rsp_x_byte,
                                                     rsp_y_byte,
                                                     rsp_send_enable_request}),
                                $realtime);
      if (long_hold_left > 0) begin
         rsp_stall <= 1'b1;
         long_hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_byte(input logic [ps2mct_pkg::RX_BYTE_W-1:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      cursor_sb.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_packet(input logic [7:0] status, input logic [7:0] dx,
                              input logic [7:0] dy);
      send_byte(status);
      send_byte(dx);
      send_byte(dy);
   endtask

   // Drop valid and hold until every queued report has come back.
   task automatic wait_for_reports();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (cursor_sb.pending.size() != 0);
   endtask

   task automatic send_random_packet();
      int         kind;
      int         dx;
      int         dy;
      logic [7:0] status;
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
         send_packet(ps2mct_pkg::ACK_BYTE, ps2mct_pkg::SELFTEST_PASS,
                     8'($urandom_range(0, 255)));
      end else if (kind < 10) begin
         // stray bytes shift the framing; the block never resyncs
         repeat ($urandom_range(1, 2))
            send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 12) begin
         send_packet(ps2mct_pkg::ACK_BYTE, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      end else if (kind < 14) begin
         send_packet(8'($urandom_range(0, 255)), ps2mct_pkg::SELFTEST_PASS,
                     8'($urandom_range(0, 255)));
      end else if (kind < 50) begin
         dx                             = int'($urandom_range(0, 40)) - 20;
         dy                             = int'($urandom_range(0, 40)) - 20;
         status                         = 8'($urandom_range(0, 255));
         status[ps2mct_pkg::X_SIGN_POS] = (dx < 0);
         status[ps2mct_pkg::Y_SIGN_POS] = (dy < 0);
         send_packet(status, dx[7:0], dy[7:0]);
      end else begin
         send_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int phase_start;
      bit hold_done;
      hold_done = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_packet(ps2mct_pkg::ACK_BYTE, ps2mct_pkg::SELFTEST_PASS, 8'h00);
      send_packet(ps2mct_pkg::ACK_BYTE, ps2mct_pkg::SELFTEST_PASS, 8'hFF);
      send_packet(8'h00, 8'hFF, 8'hFF);
      send_packet(8'h00, 8'hFF, 8'h00);
      send_packet(8'h30, 8'h00, 8'h00);
      send_packet(8'h30, 8'h00, 8'h00);
      send_packet(8'hF0, 8'h80, 8'h80);
      send_packet(8'h0F, ps2mct_pkg::SELFTEST_PASS, 8'h01);
      wait_for_reports();

      for (int phase = 0; phase < 3; phase++) begin
         unique case (phase)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 60;
            end
            1: begin
               send_idle_pct = 60;
               recv_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < ITEMS_PER_PHASE) begin
            if (phase == 0 && !hold_done && bytes_sent - phase_start >= 150) begin
               long_hold_left = LONG_HOLD;
               hold_done      = 1'b1;
            end
            send_random_packet();
         end
         wait_for_reports();
      end

      repeat (8) @(posedge clock);
      if (cursor_sb.errors == 0 && cursor_sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

### filelist.f
design/ps2mct_pkg.sv
design/ps2mct_in_stage.sv
design/ps2mct_tracker.sv
design/ps2_mouse_cursor_tracker_top.sv
design/ps2mct_checker.sv
test/testbench.sv
